// ----- hw/rtl/refcounted_handle_cache_macros.svh -----
// Assertion macros shared by the handle cache RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef REFCOUNTED_HANDLE_CACHE_MACROS_SVH
`define REFCOUNTED_HANDLE_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("handle cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("handle cache assertion failed");

`endif

// ----- hw/rtl/rhc_pkg.sv -----
// Package for the reference-counted handle cache.
// Holds sizes, operation and status codes, and the entry and scan result types.
package rhc_pkg;

    localparam int ENTRIES  = 256;
    localparam int REF_BITS = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int COLL_W   = 32;
    localparam int OBJ_W    = 64;
    localparam int VAL_W    = 20;
    localparam int OP_W     = 2;
    localparam int ST_W     = 3;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_SUCCESS   = 3'd0;
    localparam logic [ST_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [ST_W-1:0] ST_ERROR     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [REF_BITS-1:0] refs;
        logic [COLL_W-1:0]   coll;
        logic [OBJ_W-1:0]    obj;
        logic [VAL_W-1:0]    val;
    } t_entry;

    typedef struct packed {
        logic                match;
        logic [IDX_W-1:0]    m_idx;
        logic [REF_BITS-1:0] m_refs;
        logic [VAL_W-1:0]    m_val;
        logic                free_found;
        logic [IDX_W-1:0]    free_idx;
        logic                zero_found;
        logic [IDX_W-1:0]    zero_idx;
        logic [VAL_W-1:0]    zero_val;
    } t_scan_res;

endpackage

// ----- hw/rtl/rhc_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependency.
module rhc_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/rhc_scan.sv -----
// Scan engine: sweeps every table entry through the RAM read port once per item.
// Records the first key match, first free entry and first unreferenced entry; uses rhc_pkg.
module rhc_scan
    import rhc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [COLL_W-1:0]  i_coll,
    input  logic [OBJ_W-1:0]   i_obj,
    input  logic [ENTRIES-1:0] i_valid,
    input  t_entry             i_rdata,
    output logic               o_re,
    output logic [IDX_W-1:0]   o_raddr,
    output logic               o_done,
    output t_scan_res          o_res
);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pend;
    logic [IDX_W-1:0] r_pidx;
    logic             r_done;
    t_scan_res        r_res;
    t_scan_res        n_res;
    logic             w_vld;
    logic             w_key_eq;

    assign o_re    = r_busy && (r_cnt < CNT_W'(ENTRIES));
    assign o_raddr = r_cnt[IDX_W-1:0];
    assign w_vld   = i_valid[r_pidx];
    assign w_key_eq = (i_rdata.coll == i_coll) && (i_rdata.obj == i_obj);

    always_comb begin
        n_res = r_res;
        if (w_vld && w_key_eq && !r_res.match) begin
            n_res.match  = 1'b1;
            n_res.m_idx  = r_pidx;
            n_res.m_refs = i_rdata.refs;
            n_res.m_val  = i_rdata.val;
        end
        if (!w_vld && !r_res.free_found) begin
            n_res.free_found = 1'b1;
            n_res.free_idx   = r_pidx;
        end
        if (w_vld && (i_rdata.refs == '0) && !r_res.zero_found) begin
            n_res.zero_found = 1'b1;
            n_res.zero_idx   = r_pidx;
            n_res.zero_val   = i_rdata.val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_pend <= 1'b0;
                r_res  <= '0;
            end else begin
                if (o_re) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                r_pend <= o_re;
                r_pidx <= o_raddr;
                if (r_pend) begin
                    r_res <= n_res;
                    if (r_pidx == IDX_W'(ENTRIES - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- hw/rtl/refcounted_handle_cache.sv -----
// Reference-counted handle cache: one item is accepted, ENTRIES entries are scanned
// through the registered-read RAM, then the chosen entry, if any, is updated.
// A new input beat is taken only after the last result moves to the output register;
// the sequential RAM scan and output back-pressure set this.
// Synchronous active-low reset clears all valid bits at once; no clearing pass is needed.
// Uses rhc_pkg, rhc_ram, rhc_scan and the assertion macro header.
`include "refcounted_handle_cache_macros.svh"

module refcounted_handle_cache
    import rhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [COLL_W-1:0] i_collection_key,
    input  logic [OBJ_W-1:0]  i_object_key,
    input  logic [VAL_W-1:0]  i_install_value,
    input  logic              i_install_ok,
    input  logic              i_delete_ok,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [VAL_W-1:0]  o_result_value,
    output logic              o_hit,
    output logic              o_release_valid,
    output logic [VAL_W-1:0]  o_release_value
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         r_state;
    logic               r_start;
    logic [OP_W-1:0]    r_op;
    logic [COLL_W-1:0]  r_coll;
    logic [OBJ_W-1:0]   r_obj;
    logic [VAL_W-1:0]   r_ival;
    logic               r_iok;
    logic               r_dok;
    logic [ENTRIES-1:0] r_valid;

    logic [ST_W-1:0]    r_res_status;
    logic [VAL_W-1:0]   r_res_rval;
    logic               r_res_hit;
    logic               r_res_rel;
    logic [VAL_W-1:0]   r_res_relval;

    logic               r_out_vld;
    logic [ST_W-1:0]    r_out_status;
    logic [VAL_W-1:0]   r_out_rval;
    logic               r_out_hit;
    logic               r_out_rel;
    logic [VAL_W-1:0]   r_out_relval;

    logic               w_accept;
    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    t_entry             w_rdata;
    logic               w_done;
    t_scan_res          w_sr;
    logic               w_load_out;

    logic               n_we;
    logic [IDX_W-1:0]   n_waddr;
    t_entry             n_wdata;
    logic               n_vset;
    logic               n_vclr;
    logic [IDX_W-1:0]   n_vidx;
    logic [ST_W-1:0]    n_status;
    logic [VAL_W-1:0]   n_rval;
    logic               n_hit;
    logic               n_rel;
    logic [VAL_W-1:0]   n_relval;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_OUT) && (!r_out_vld || i_out_ready);

    rhc_ram #(
        .DEPTH(ENTRIES),
        .WIDTH($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rhc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_coll  (r_coll),
        .i_obj   (r_obj),
        .i_valid (r_valid),
        .i_rdata (w_rdata),
        .o_re    (w_re),
        .o_raddr (w_raddr),
        .o_done  (w_done),
        .o_res   (w_sr)
    );

    always_comb begin
        n_we     = 1'b0;
        n_waddr  = w_sr.m_idx;
        n_wdata  = '{refs: w_sr.m_refs, coll: r_coll, obj: r_obj, val: w_sr.m_val};
        n_vset   = 1'b0;
        n_vclr   = 1'b0;
        n_vidx   = w_sr.m_idx;
        n_status = ST_ERROR;
        n_rval   = '0;
        n_hit    = 1'b0;
        n_rel    = 1'b0;
        n_relval = '0;
        if (w_done) begin
            case (r_op)
                OP_GET: begin
                    if (w_sr.match) begin
                        n_we     = 1'b1;
                        if (w_sr.m_refs != '1) begin
                            n_wdata.refs = w_sr.m_refs + REF_BITS'(1);
                        end
                        n_status = ST_SUCCESS;
                        n_rval   = w_sr.m_val;
                        n_hit    = 1'b1;
                    end else if (w_sr.free_found || w_sr.zero_found) begin
                        n_vidx  = w_sr.free_found ? w_sr.free_idx : w_sr.zero_idx;
                        n_waddr = n_vidx;
                        if (!w_sr.free_found) begin
                            n_rel    = 1'b1;
                            n_relval = w_sr.zero_val;
                            n_vclr   = 1'b1;
                        end
                        if (r_iok) begin
                            n_we     = 1'b1;
                            n_wdata  = '{refs: REF_BITS'(1), coll: r_coll, obj: r_obj,
                                         val: r_ival};
                            n_vset   = 1'b1;
                            n_vclr   = 1'b0;
                            n_status = ST_SUCCESS;
                            n_rval   = r_ival;
                        end else begin
                            n_status = ST_ERROR;
                        end
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_PUT: begin
                    if (w_sr.match) begin
                        n_we = 1'b1;
                        if (w_sr.m_refs != '0) begin
                            n_wdata.refs = w_sr.m_refs - REF_BITS'(1);
                        end
                        n_status = ST_SUCCESS;
                        n_hit    = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                OP_REMOVE: begin
                    if (w_sr.match && (w_sr.m_refs != '0)) begin
                        n_status = ST_BUSY;
                        n_hit    = 1'b1;
                    end else begin
                        if (w_sr.match) begin
                            n_hit    = 1'b1;
                            n_rel    = 1'b1;
                            n_relval = w_sr.m_val;
                            n_vclr   = 1'b1;
                        end
                        n_status = r_dok ? ST_SUCCESS : ST_ERROR;
                    end
                end
                default: begin
                    n_status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (n_vset) begin
                r_valid[n_vidx] <= 1'b1;
            end else if (n_vclr) begin
                r_valid[n_vidx] <= 1'b0;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SCAN;
                        r_start <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_coll <= i_collection_key;
            r_obj  <= i_object_key;
            r_ival <= i_install_value;
            r_iok  <= i_install_ok;
            r_dok  <= i_delete_ok;
        end
        if (w_done) begin
            r_res_status <= n_status;
            r_res_rval   <= n_rval;
            r_res_hit    <= n_hit;
            r_res_rel    <= n_rel;
            r_res_relval <= n_relval;
        end
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_rval   <= r_res_rval;
            r_out_hit    <= r_res_hit;
            r_out_rel    <= r_res_rel;
            r_out_relval <= r_res_relval;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_result_value  = r_out_rval;
    assign o_hit           = r_out_hit;
    assign o_release_valid = r_out_rel;
    assign o_release_value = r_out_relval;

    `RHC_ASSERT_IMP(a_done_in_scan, w_done, r_state == S_SCAN)
    `RHC_ASSERT_IMP(a_no_rw_overlap, n_we, !w_re)
    `RHC_ASSERT_NXT(a_accept_starts_scan, w_accept, r_state == S_SCAN && r_start)
    `RHC_ASSERT_IMP(a_full_no_hit, o_out_valid && o_status == ST_FULL, !o_hit && !o_release_valid)
    `RHC_ASSERT_IMP(a_release_status, o_out_valid && o_release_valid,
                    o_status == ST_SUCCESS || o_status == ST_ERROR)

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for refcounted_handle_cache: a directed table, then random
// get/put/remove/unused-op traffic under several sender and receiver idling mixes.
// Depends on rhc_pkg and its RTL; results come from a local model or typed directed rows.
module tb;
    import rhc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam int KEY_W = COLL_W + OBJ_W;
    localparam int POOL_SIZE = 24;
    localparam int STALL_LIMIT = 16 * (ENTRIES + 5);
    localparam int PRINT_LIMIT = 20;

    typedef logic [KEY_W-1:0] cache_key_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COLL_W-1:0] coll;
        logic [OBJ_W-1:0]  obj;
        logic [VAL_W-1:0]  ival;
        logic              install_ok;
        logic              delete_ok;
    } cache_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value;
        logic             hit;
        logic             rel;
        logic [VAL_W-1:0] rel_value;
    } cache_reply_t;

    typedef struct packed {
        cache_req_t   rq;
        logic         typed;
        cache_reply_t rp;
    } directed_row_t;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op = OP_GET;
    logic [COLL_W-1:0] i_collection_key = '0;
    logic [OBJ_W-1:0]  i_object_key = '0;
    logic [VAL_W-1:0]  i_install_value = '0;
    logic              i_install_ok = 1'b0;
    logic              i_delete_ok = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [VAL_W-1:0]  o_result_value;
    logic              o_hit;
    logic              o_release_valid;
    logic [VAL_W-1:0]  o_release_value;

    logic              row_typed = 1'b0;
    cache_reply_t      row_reply = '0;

    int unsigned       idle_pct = 0;
    int unsigned       stall_pct = 0;
    int                check_errors = 0;
    int                quiet_cycles = 0;

    logic              tbl_valid [ENTRIES];
    logic [REF_BITS-1:0] tbl_refs [ENTRIES];
    logic [COLL_W-1:0] tbl_coll [ENTRIES];
    logic [OBJ_W-1:0]  tbl_obj [ENTRIES];
    logic [VAL_W-1:0]  tbl_val [ENTRIES];

    cache_reply_t      pending_replies [$];
    directed_row_t     directed_rows [$];
    cache_key_t        key_pool [POOL_SIZE];
    cache_key_t        filled_keys [$];

    refcounted_handle_cache i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_collection_key (i_collection_key),
        .i_object_key     (i_object_key),
        .i_install_value  (i_install_value),
        .i_install_ok     (i_install_ok),
        .i_delete_ok      (i_delete_ok),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_hit            (o_hit),
        .o_release_valid  (o_release_valid),
        .o_release_value  (o_release_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic cache_reply_t cache_lookup(input cache_req_t rq);
        cache_reply_t rp;
        int hit_idx;
        int slot;
        rp = '0;
        rp.status = ST_ERROR;
        hit_idx = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES && hit_idx < 0; i++) begin
            if (tbl_valid[i] && tbl_coll[i] == rq.coll && tbl_obj[i] == rq.obj)
                hit_idx = i;
        end
        case (rq.op)
            OP_GET: begin
                if (hit_idx >= 0) begin
                    if (tbl_refs[hit_idx] != REF_MAX)
                        tbl_refs[hit_idx] = tbl_refs[hit_idx] + REF_BITS'(1);
                    rp.status = ST_SUCCESS;
                    rp.value = tbl_val[hit_idx];
                    rp.hit = 1'b1;
                end else begin
                    for (int i = 0; i < ENTRIES && slot < 0; i++) begin
                        if (!tbl_valid[i])
                            slot = i;
                    end
                    for (int i = 0; i < ENTRIES && slot < 0; i++) begin
                        if (tbl_refs[i] == '0)
                            slot = i;
                    end
                    if (slot < 0) begin
                        rp.status = ST_FULL;
                    end else begin
                        if (tbl_valid[slot]) begin
                            rp.rel = 1'b1;
                            rp.rel_value = tbl_val[slot];
                            tbl_valid[slot] = 1'b0;
                        end
                        if (rq.install_ok) begin
                            tbl_valid[slot] = 1'b1;
                            tbl_refs[slot] = REF_BITS'(1);
                            tbl_coll[slot] = rq.coll;
                            tbl_obj[slot] = rq.obj;
                            tbl_val[slot] = rq.ival;
                            rp.status = ST_SUCCESS;
                            rp.value = rq.ival;
                        end
                    end
                end
            end
            OP_PUT: begin
                if (hit_idx >= 0) begin
                    if (tbl_refs[hit_idx] != '0)
                        tbl_refs[hit_idx] = tbl_refs[hit_idx] - REF_BITS'(1);
                    rp.status = ST_SUCCESS;
                    rp.hit = 1'b1;
                end else begin
                    rp.status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (hit_idx >= 0 && tbl_refs[hit_idx] != '0) begin
                    rp.status = ST_BUSY;
                    rp.hit = 1'b1;
                end else begin
                    if (hit_idx >= 0) begin
                        rp.hit = 1'b1;
                        rp.rel = 1'b1;
                        rp.rel_value = tbl_val[hit_idx];
                        tbl_valid[hit_idx] = 1'b0;
                    end
                    rp.status = rq.delete_ok ? ST_SUCCESS : ST_ERROR;
                end
            end
            default: ;
        endcase
        return rp;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        check_errors++;
        if (check_errors <= PRINT_LIMIT)
            $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : beat_monitor
        cache_req_t   rq;
        cache_reply_t want;
        logic         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && o_in_ready) begin
                rq = {i_op, i_collection_key, i_object_key, i_install_value,
                      i_install_ok, i_delete_ok};
                want = cache_lookup(rq);
                if (row_typed)
                    want = row_reply;
                pending_replies.push_back(want);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'(o_status), '0);
                end else begin
                    want = pending_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_result_value !== want.value)
                        report_mismatch("result_value", 32'(o_result_value),
                                        32'(want.value));
                    if (o_hit !== want.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                    if (o_release_valid !== want.rel)
                        report_mismatch("release_valid", 32'(o_release_valid),
                                        32'(want.rel));
                    if (o_release_value !== want.rel_value)
                        report_mismatch("release_value", 32'(o_release_value),
                                        32'(want.rel_value));
                end
            end
            if (moved)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic add_row(input logic [OP_W-1:0] op, input cache_key_t key,
                           input logic [VAL_W-1:0] ival, input logic iok, input logic dok,
                           input logic typed, input logic [ST_W-1:0] st,
                           input logic [VAL_W-1:0] val, input logic hit, input logic rel,
                           input logic [VAL_W-1:0] rel_val);
        directed_row_t row;
        row.rq = {op, key, ival, iok, dok};
        row.typed = typed;
        row.rp = {st, val, hit, rel, rel_val};
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the input beat.
    task automatic send_request(input cache_req_t rq, input logic typed,
                                input cache_reply_t rp);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= rq.op;
        i_collection_key <= rq.coll;
        i_object_key <= rq.obj;
        i_install_value <= rq.ival;
        i_install_ok <= rq.install_ok;
        i_delete_ok <= rq.delete_ok;
        row_typed <= typed;
        row_reply <= rp;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cache_req_t random_request();
        cache_req_t rq;
        cache_key_t key;
        int unsigned pick;
        pick = $urandom_range(99);
        rq.op = (pick < 45) ? OP_GET : (pick < 75) ? OP_PUT : (pick < 97) ? OP_REMOVE : OP_UNUSED;
        pick = $urandom_range(99);
        if (filled_keys.size() > 0 && pick < 30)
            key = filled_keys[$urandom_range(filled_keys.size() - 1)];
        else if (pick < 90)
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else
            key = {$urandom, $urandom, $urandom};
        {rq.coll, rq.obj} = key;
        rq.ival = VAL_W'($urandom);
        rq.install_ok = ($urandom_range(99) < 88);
        rq.delete_ok = 1'($urandom_range(1));
        return rq;
    endfunction

    task automatic start_phase(input int unsigned sender_idle, input int unsigned recv_stall);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
        idle_pct = sender_idle;
        stall_pct = recv_stall;
    endtask

    task automatic random_traffic(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_request(), 1'b0, '0);
    endtask

    initial begin : stimulus
        cache_req_t rq;
        cache_key_t key;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_refs[i] = '0;
            tbl_coll[i] = '0;
            tbl_obj[i] = '0;
            tbl_val[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom, $urandom};
        key_pool[0] = '1;
        key_pool[1] = '0;

        add_row(OP_PUT,    '1, '0, 1'b1, 1'b1, 1'b1, ST_NOT_FOUND, '0, 1'b0, 1'b0, '0);
        add_row(OP_REMOVE, '1, '0, 1'b1, 1'b1, 1'b1, ST_SUCCESS,   '0, 1'b0, 1'b0, '0);
        add_row(OP_REMOVE, '1, '0, 1'b1, 1'b0, 1'b1, ST_ERROR,     '0, 1'b0, 1'b0, '0);
        add_row(OP_UNUSED, '1, '1, 1'b1, 1'b1, 1'b1, ST_ERROR,     '0, 1'b0, 1'b0, '0);
        add_row(OP_GET,    '1, '1, 1'b0, 1'b1, 1'b1, ST_ERROR,     '0, 1'b0, 1'b0, '0);
        add_row(OP_GET,    '1, '1, 1'b1, 1'b0, 1'b1, ST_SUCCESS,   '1, 1'b0, 1'b0, '0);
        add_row(OP_GET,    '1, '0, 1'b1, 1'b0, 1'b1, ST_SUCCESS,   '1, 1'b1, 1'b0, '0);
        add_row(OP_REMOVE, '1, '0, 1'b1, 1'b1, 1'b1, ST_BUSY,      '0, 1'b1, 1'b0, '0);
        add_row(OP_PUT,    '1, '0, 1'b0, 1'b0, 1'b1, ST_SUCCESS,   '0, 1'b1, 1'b0, '0);
        add_row(OP_PUT,    '1, '0, 1'b0, 1'b0, 1'b1, ST_SUCCESS,   '0, 1'b1, 1'b0, '0);
        add_row(OP_PUT,    '1, '0, 1'b0, 1'b0, 1'b1, ST_SUCCESS,   '0, 1'b1, 1'b0, '0);
        add_row(OP_REMOVE, '1, '0, 1'b1, 1'b0, 1'b1, ST_ERROR,     '0, 1'b1, 1'b1, '1);
        add_row(OP_GET, '1, 20'h12345, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_GET, '0, '0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_GET, {{COLL_W{1'b0}}, {OBJ_W{1'b1}}}, 20'hA5A5A, 1'b1, 1'b1,
                1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_GET, {{COLL_W{1'b1}}, {OBJ_W{1'b0}}}, 20'h5A5A5, 1'b1, 1'b0,
                1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_GET, {{COLL_W{1'b1}}, {OBJ_W{1'b0}}}, 20'h0F0F0, 1'b1, 1'b0,
                1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_PUT, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_PUT, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_REMOVE, '0, '0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_REMOVE, {{COLL_W{1'b0}}, {OBJ_W{1'b1}}}, '0, 1'b0, 1'b1,
                1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_PUT, {{COLL_W{1'b0}}, {OBJ_W{1'b1}}}, '0, 1'b0, 1'b0,
                1'b0, '0, '0, 1'b0, 1'b0, '0);
        add_row(OP_REMOVE, {{COLL_W{1'b0}}, {OBJ_W{1'b1}}}, '0, 1'b0, 1'b0,
                1'b0, '0, '0, 1'b0, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            send_request(directed_rows[r].rq, directed_rows[r].typed, directed_rows[r].rp);

        start_phase(0, 0);
        random_traffic(150);
        start_phase(63, 0);
        random_traffic(150);
        start_phase(0, 63);
        random_traffic(150);
        start_phase(36, 36);

        // Fresh keys claim all unreferenced entries, so the last gets find the table full.
        for (int n = 0; n < ENTRIES + 8; n++) begin
            key = {$urandom, $urandom, $urandom};
            filled_keys.push_back(key);
            rq.op = OP_GET;
            {rq.coll, rq.obj} = key;
            rq.ival = VAL_W'($urandom);
            rq.install_ok = (n < ENTRIES) ? 1'b1 : 1'($urandom_range(1));
            rq.delete_ok = 1'($urandom_range(1));
            send_request(rq, 1'b0, '0);
        end
        random_traffic(60);

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (ENTRIES + 5) @(negedge i_clk);
        if (check_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_ram.sv
hw/rtl/rhc_scan.sv
hw/rtl/refcounted_handle_cache.sv
verif/tb.sv
